// File: src/alr_pkg.sv
// alr_pkg: shared types and constants of the antialiased line rasterizer.
// Used by antialiased_line_rasterizer and alr_checker; no dependencies.
package alr_pkg;

  // Fixed-point format and coordinate width
  localparam int unsigned FRAC_BITS  = 7;
  localparam int unsigned COORD_BITS = 9;
  localparam int unsigned PIX_W      = COORD_BITS + 1;
  localparam int unsigned ACC_W      = COORD_BITS + FRAC_BITS;
  localparam int unsigned SLOPE_W    = FRAC_BITS + 2;
  localparam int unsigned QUOT_W     = FRAC_BITS + 1;
  localparam int unsigned DIV_CNT_W  = $clog2(FRAC_BITS + 1);
  localparam int unsigned COV_W      = 8;

  localparam logic [COV_W-1:0] FULL_BRIGHT = 8'd255;

  // Item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWAP,
    S_ORDER,
    S_DIV,
    S_EMIT_LO,
    S_EMIT_HI
  } state_e;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [COV_W-1:0] coverage;
    logic             last;
    logic             line_done;
  } out_t;

endpackage

// File: src/antialiased_line_rasterizer.sv
// antialiased_line_rasterizer: antialiased line stepper with a bit-serial
// slope divider and a one-entry output register. Uses alr_pkg.
// Start item: accepted in S_IDLE, then setup in S_SWAP and S_ORDER and a bit-serial
//   slope divide in S_DIV on the shared subtractor (no divide for a point line); no pixels.
// Step item: a registered pixel from S_EMIT_LO and one from S_EMIT_HI (S_EMIT_LO only for
//   a point line, none while no line is active); stalls follow out_ready_i.
// rst_ni (async, active low) clears the sequencer, the active/steep/point flags and out_valid_o.
module antialiased_line_rasterizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  alr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output alr_pkg::out_t out_data_o
);

  localparam int unsigned CB = alr_pkg::COORD_BITS;
  localparam int unsigned FB = alr_pkg::FRAC_BITS;
  localparam logic [alr_pkg::DIV_CNT_W-1:0] DIV_LAST = alr_pkg::DIV_CNT_W'(FB);

  // Map a major/minor pixel back to screen axes
  function automatic alr_pkg::out_t make_pixel(
    input logic [alr_pkg::PIX_W-1:0] major,
    input logic [alr_pkg::PIX_W-1:0] minor,
    input logic [alr_pkg::COV_W-1:0] cov,
    input logic                      lastp,
    input logic                      done,
    input logic                      steep
  );
    alr_pkg::out_t p;
    p.pixel_x   = steep ? minor : major;
    p.pixel_y   = steep ? major : minor;
    p.coverage  = cov;
    p.last      = lastp;
    p.line_done = done;
    return p;
  endfunction

  // 255*w >> FRAC_BITS, done as (w<<8) - w
  function automatic logic [alr_pkg::COV_W-1:0] scale_cov(input logic [FB:0] w);
    logic [FB+alr_pkg::COV_W:0] prod;
    prod = ({w, {alr_pkg::COV_W{1'b0}}}) - (FB + alr_pkg::COV_W + 1)'(w);
    return prod[FB+alr_pkg::COV_W-1:FB];
  endfunction

  alr_pkg::state_e state_q, state_d;

  logic active_q, active_d;
  logic steep_q, steep_d;
  logic point_q, point_d;
  logic neg_q, neg_d;
  logic [CB-1:0] p0x_q, p0x_d, p0y_q, p0y_d, p1x_q, p1x_d, p1y_q, p1y_d;
  logic [CB-1:0] column_q, column_d, last_col_q, last_col_d;
  logic [alr_pkg::ACC_W-1:0]     accum_q, accum_d;
  logic [alr_pkg::SLOPE_W-1:0]   slope_q, slope_d;
  logic [CB:0]                   rem_q, rem_d;
  logic [CB-1:0]                 den_q, den_d;
  logic [alr_pkg::QUOT_W-1:0]    quot_q, quot_d;
  logic [alr_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  logic          out_valid_q, out_valid_d;
  alr_pkg::out_t out_q, out_d;

  // Combinational helpers
  logic                       in_fire, out_free;
  logic [CB-1:0]              adx, ady, dx, dy_abs;
  logic                       ge;
  logic [CB:0]                rem_sub;
  logic [CB-1:0]              rem_sel;
  logic [alr_pkg::QUOT_W-1:0] quot_new;
  logic [alr_pkg::SLOPE_W-1:0] quot_ext;
  logic [CB-1:0]              row;
  logic [FB-1:0]              frac;
  logic                       col_done;

  assign in_ready_o  = (state_q == alr_pkg::S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Endpoint distances for the steep test and the ordered deltas
  assign adx    = (p1x_q > p0x_q) ? (p1x_q - p0x_q) : (p0x_q - p1x_q);
  assign ady    = (p1y_q > p0y_q) ? (p1y_q - p0y_q) : (p0y_q - p1y_q);
  assign dx     = adx;
  assign dy_abs = ady;

  // Shared subtractor of the restoring divider
  assign rem_sub  = rem_q - {1'b0, den_q};
  assign ge       = (rem_q >= {1'b0, den_q});
  assign rem_sel  = ge ? rem_sub[CB-1:0] : rem_q[CB-1:0];
  assign quot_new = {quot_q[alr_pkg::QUOT_W-2:0], ge};
  assign quot_ext = {1'b0, quot_new};

  // Current column view
  assign row      = accum_q[alr_pkg::ACC_W-1:FB];
  assign frac     = accum_q[FB-1:0];
  assign col_done = (column_q == last_col_q);

  // Sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    steep_d     = steep_q;
    point_d     = point_q;
    neg_d       = neg_q;
    p0x_d       = p0x_q;
    p0y_d       = p0y_q;
    p1x_d       = p1x_q;
    p1y_d       = p1y_q;
    column_d    = column_q;
    last_col_d  = last_col_q;
    accum_d     = accum_q;
    slope_d     = slope_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quot_d      = quot_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;

    case (state_q)
      alr_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.kind == alr_pkg::KIND_START) begin
            p0x_d   = in_data_i.start_x;
            p0y_d   = in_data_i.start_y;
            p1x_d   = in_data_i.end_x;
            p1y_d   = in_data_i.end_y;
            state_d = alr_pkg::S_SWAP;
          end else if (active_q) begin
            state_d = alr_pkg::S_EMIT_LO;
          end
        end
      end
      alr_pkg::S_SWAP: begin
        // steep lines run along y
        steep_d = (ady > adx);
        if (ady > adx) begin
          p0x_d = p0y_q;
          p0y_d = p0x_q;
          p1x_d = p1y_q;
          p1y_d = p1x_q;
        end
        state_d = alr_pkg::S_ORDER;
      end
      alr_pkg::S_ORDER: begin
        // order by major axis and load the divider
        if (p0x_q > p1x_q) begin
          column_d   = p1x_q;
          last_col_d = p0x_q;
          accum_d    = {p1y_q, {FB{1'b0}}};
          neg_d      = (p0y_q < p1y_q);
        end else begin
          column_d   = p0x_q;
          last_col_d = p1x_q;
          accum_d    = {p0y_q, {FB{1'b0}}};
          neg_d      = (p1y_q < p0y_q);
        end
        den_d  = dx;
        rem_d  = {1'b0, dy_abs};
        quot_d = '0;
        cnt_d  = '0;
        if (dx == '0) begin
          point_d  = 1'b1;
          slope_d  = '0;
          active_d = 1'b1;
          state_d  = alr_pkg::S_IDLE;
        end else begin
          point_d = 1'b0;
          state_d = alr_pkg::S_DIV;
        end
      end
      alr_pkg::S_DIV: begin
        // one quotient bit per cycle
        rem_d  = {rem_sel, 1'b0};
        quot_d = quot_new;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          slope_d  = neg_q ? (~quot_ext + alr_pkg::SLOPE_W'(1)) : quot_ext;
          active_d = 1'b1;
          state_d  = alr_pkg::S_IDLE;
        end
      end
      alr_pkg::S_EMIT_LO: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (point_q) begin
            out_d    = make_pixel({1'b0, column_q}, {1'b0, row}, alr_pkg::FULL_BRIGHT,
                                  1'b1, 1'b1, steep_q);
            active_d = 1'b0;
            state_d  = alr_pkg::S_IDLE;
          end else begin
            out_d   = make_pixel({1'b0, column_q}, {1'b0, row},
                                 scale_cov((FB + 1)'(1 << FB) - {1'b0, frac}),
                                 1'b0, 1'b0, steep_q);
            state_d = alr_pkg::S_EMIT_HI;
          end
        end
      end
      alr_pkg::S_EMIT_HI: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d   = make_pixel({1'b0, column_q}, {1'b0, row} + alr_pkg::PIX_W'(1),
                               scale_cov({1'b0, frac}), 1'b1, col_done, steep_q);
          accum_d = accum_q + {{(alr_pkg::ACC_W - alr_pkg::SLOPE_W){slope_q[alr_pkg::SLOPE_W-1]}},
                               slope_q};
          if (col_done) begin
            active_d = 1'b0;
          end else begin
            column_d = column_q + 1'b1;
          end
          state_d = alr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = alr_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alr_pkg::S_IDLE;
      active_q    <= 1'b0;
      steep_q     <= 1'b0;
      point_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      steep_q     <= steep_d;
      point_q     <= point_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    p0x_q      <= p0x_d;
    p0y_q      <= p0y_d;
    p1x_q      <= p1x_d;
    p1y_q      <= p1y_d;
    column_q   <= column_d;
    last_col_q <= last_col_d;
    accum_q    <= accum_d;
    slope_q    <= slope_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    quot_q     <= quot_d;
    out_q      <= out_d;
  end

endmodule

// File: src/alr_checker.sv
// alr_port_asserts: port-level assertions for antialiased_line_rasterizer,
// attached by the bind below. Uses alr_pkg.
module alr_port_asserts (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input alr_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input alr_pkg::out_t out_data_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // End of line only on the final pixel of a step
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_done |-> out_data_o.last)
    else $error("line_done without last");

  // Starting a line keeps the block busy for setup and divide
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.kind == alr_pkg::KIND_START) |=> !in_ready_o)
    else $error("ready right after a line start");

  // While the first pixel of a pair is pending, the second is still owed
  a_pair_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("ready while a pixel pair is incomplete");

endmodule

bind antialiased_line_rasterizer alr_port_asserts u_alr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: tb/alr_checker.sv
// alr_checker: passive monitor for the antialiased line rasterizer. Predicts
// the pixel stream from accepted items and compares it. Depends on alr_pkg.
`timescale 1ns / 1ps

module alr_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  alr_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  alr_pkg::out_t out_data_i,
  output int unsigned   fail_count_o,
  output int unsigned   pending_o
);

  // Shadow of the line stepper
  logic                           line_active;
  logic                           swap_axes;
  logic                           single_point;
  logic [alr_pkg::COORD_BITS-1:0] cur_col;
  logic [alr_pkg::COORD_BITS-1:0] end_col;
  logic [alr_pkg::ACC_W-1:0]      row_fp;
  int                             row_step;

  alr_pkg::out_t expected_pixels[$];
  alr_pkg::out_t want;
  int unsigned   mismatches = 0;

  // Build one pixel, mapping major/minor back to screen axes
  function automatic alr_pkg::out_t make_pixel(int major, int minor, int cov,
                                               bit last, bit done);
    alr_pkg::out_t p;
    p.pixel_x   = alr_pkg::PIX_W'(swap_axes ? minor : major);
    p.pixel_y   = alr_pkg::PIX_W'(swap_axes ? major : minor);
    p.coverage  = alr_pkg::COV_W'(cov);
    p.last      = last;
    p.line_done = done;
    return p;
  endfunction

  // Advance the shadow state by one item and queue the pixels it produces
  function automatic void rasterize_item(alr_pkg::in_t item);
    int ax, ay, bx, by, adx, ady, tmp, dx, dy;
    int row, frac, one_fp;
    bit done;
    one_fp = 1 << alr_pkg::FRAC_BITS;
    if (item.kind == alr_pkg::KIND_START) begin
      ax  = int'(item.start_x);
      ay  = int'(item.start_y);
      bx  = int'(item.end_x);
      by  = int'(item.end_y);
      adx = (bx > ax) ? bx - ax : ax - bx;
      ady = (by > ay) ? by - ay : ay - by;
      swap_axes = (ady > adx);
      if (swap_axes) begin
        tmp = ax; ax = ay; ay = tmp;
        tmp = bx; bx = by; by = tmp;
      end
      // walk the major axis left to right
      if (ax > bx) begin
        tmp = ax; ax = bx; bx = tmp;
        tmp = ay; ay = by; by = tmp;
      end
      dx           = bx - ax;
      dy           = by - ay;
      cur_col      = alr_pkg::COORD_BITS'(ax);
      end_col      = alr_pkg::COORD_BITS'(bx);
      row_fp       = alr_pkg::ACC_W'(ay << alr_pkg::FRAC_BITS);
      single_point = (dx == 0);
      // int division truncates toward zero
      row_step     = single_point ? 0 : (dy * one_fp) / dx;
      line_active  = 1'b1;
    end else if (line_active) begin
      row = int'(row_fp >> alr_pkg::FRAC_BITS);
      if (single_point) begin
        expected_pixels.push_back(make_pixel(cur_col, row, alr_pkg::FULL_BRIGHT,
                                             1'b1, 1'b1));
        line_active = 1'b0;
      end else begin
        frac = int'(row_fp) & (one_fp - 1);
        done = (cur_col == end_col);
        expected_pixels.push_back(make_pixel(cur_col, row,
          (int'(alr_pkg::FULL_BRIGHT) * (one_fp - frac)) >> alr_pkg::FRAC_BITS,
          1'b0, 1'b0));
        expected_pixels.push_back(make_pixel(cur_col, row + 1,
          (int'(alr_pkg::FULL_BRIGHT) * frac) >> alr_pkg::FRAC_BITS, 1'b1, done));
        row_fp = alr_pkg::ACC_W'(int'(row_fp) + row_step);
        if (done) begin
          line_active = 1'b0;
        end else begin
          cur_col = cur_col + 1'b1;
        end
      end
    end
  endfunction

  function automatic void compare_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Sample both channels on the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_active  = 1'b0;
      swap_axes    = 1'b0;
      single_point = 1'b0;
      cur_col      = '0;
      end_col      = '0;
      row_fp       = '0;
      row_step     = 0;
      expected_pixels.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (in_valid_i && in_ready_i) begin
        rasterize_item(in_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel transfer: x %0d y %0d coverage %0d",
                 out_data_i.pixel_x, out_data_i.pixel_y, out_data_i.coverage);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          compare_field("pixel_x", want.pixel_x, out_data_i.pixel_x);
          compare_field("pixel_y", want.pixel_y, out_data_i.pixel_y);
          compare_field("coverage", want.coverage, out_data_i.coverage);
          compare_field("last", want.last, out_data_i.last);
          compare_field("line_done", want.line_done, out_data_i.line_done);
        end
      end
      pending_o    <= expected_pixels.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: tb/tb_top.sv
// tb_top: stimulus and verdict for antialiased_line_rasterizer. Draws directed
// and random lines with random gaps and stalls; alr_checker does the checking.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_COORD    = (1 << alr_pkg::COORD_BITS) - 1;
  localparam int RANDOM_ITEMS = 1750;
  localparam int PHASE_ITEMS  = 250;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  alr_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  alr_pkg::out_t out_data_o;
  int unsigned   fail_count;
  int unsigned   pending_pixels;

  bit quiet_phase = 1'b0;
  int line_items  = 0;

  antialiased_line_rasterizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  alr_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_pixels)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int gap_len();
    int pick;
    if (quiet_phase) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Nearby coordinate, reflected back into range at the screen edge
  function automatic int offset_coord(int base, int mag);
    int v;
    v = $urandom_range(0, 1) ? base + mag : base - mag;
    if (v < 0 || v > MAX_COORD) v = 2 * base - v;
    return v;
  endfunction

  // Endpoint fields are ignored on a step, so fill them with noise
  function automatic alr_pkg::in_t step_item();
    alr_pkg::in_t item;
    item.kind    = alr_pkg::KIND_STEP;
    item.start_x = alr_pkg::COORD_BITS'($urandom_range(0, MAX_COORD));
    item.start_y = alr_pkg::COORD_BITS'($urandom_range(0, MAX_COORD));
    item.end_x   = alr_pkg::COORD_BITS'($urandom_range(0, MAX_COORD));
    item.end_y   = alr_pkg::COORD_BITS'($urandom_range(0, MAX_COORD));
    return item;
  endfunction

  // One input transfer; valid holds until accepted
  task automatic send_item(input alr_pkg::in_t item);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Start a line and issue a number of column steps
  task automatic draw_line(input int ax, input int ay, input int bx, input int by,
                           input int nsteps);
    alr_pkg::in_t item;
    item.kind    = alr_pkg::KIND_START;
    item.start_x = alr_pkg::COORD_BITS'(ax);
    item.start_y = alr_pkg::COORD_BITS'(ay);
    item.end_x   = alr_pkg::COORD_BITS'(bx);
    item.end_y   = alr_pkg::COORD_BITS'(by);
    send_item(item);
    repeat (nsteps) send_item(step_item());
    line_items += nsteps + 1;
  endtask

  // Hold off the sender until every queued pixel has been transferred
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels != 0) @(posedge clk_i);
  endtask

  // Pixel sink with random backpressure
  initial begin : pixel_sink
    int stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = gap_len();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int ax, ay, bx, by, adx, ady, span, nsteps, shape, cut, phase_mark;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle step, point lines at both corners, steps past the end,
    // lines touching the field extremes, flat, diagonal and steep slopes,
    // and a restart while a line is in progress
    send_item(step_item());
    draw_line(0, 0, 0, 0, 1);
    draw_line(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 1);
    send_item(step_item());
    draw_line(MAX_COORD, MAX_COORD, MAX_COORD - 3, MAX_COORD - 2, 4);
    draw_line(0, MAX_COORD, 3, MAX_COORD - 3, 4);
    draw_line(1, 0, 0, 3, 4);
    draw_line(0, 0, 9, 4, 2);
    draw_line(100, 200, 101, 200, 2);
    wait_drained();

    // Random lines, in phases separated by a full drain
    line_items = 0;
    phase_mark = 0;
    while (line_items < RANDOM_ITEMS) begin
      if (line_items >= phase_mark) begin
        wait_drained();
        quiet_phase = ($urandom_range(0, 3) == 0);
        phase_mark  = line_items + PHASE_ITEMS;
      end
      shape = $urandom_range(0, 199);
      ax    = $urandom_range(0, MAX_COORD);
      ay    = $urandom_range(0, MAX_COORD);
      if (shape < 3) begin
        // long line anywhere on screen
        bx = $urandom_range(0, MAX_COORD);
        by = $urandom_range(0, MAX_COORD);
      end else if (shape < 20) begin
        bx = ax;
        by = ay;
      end else begin
        bx = offset_coord(ax, $urandom_range(0, 12));
        by = offset_coord(ay, $urandom_range(0, 12));
      end
      adx    = (bx > ax) ? bx - ax : ax - bx;
      ady    = (by > ay) ? by - ay : ay - by;
      span   = ((adx > ady) ? adx : ady) + 1;
      nsteps = span;
      cut    = $urandom_range(0, 99);
      // some lines are abandoned early by the next start
      if (cut < 10) nsteps = $urandom_range(0, span - 1);
      draw_line(ax, ay, bx, by, nsteps);
      // stray steps after the line has ended
      if (cut >= 92) repeat ($urandom_range(1, 2)) send_item(step_item());
    end

    quiet_phase = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/alr_pkg.sv
src/antialiased_line_rasterizer.sv
src/alr_checker.sv
tb/alr_checker.sv
tb/tb_top.sv
